@@ rtl/slid_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// slid_pkg
// Shared types and codes for the sorted list unit: operation and status codes,
// cell commands and the input and result beat layouts.
// ----------------------------------------------------------------------------
package slid_pkg;

  localparam int DEPTH_DEF = 16;
  localparam int VAL_W     = 32;

  // operation codes
  localparam logic [1:0] OP_INSERT = 2'd0;
  localparam logic [1:0] OP_DELETE = 2'd1;
  localparam logic [1:0] OP_SHOW   = 2'd2;
  localparam logic [1:0] OP_NONE   = 2'd3;

  // status codes
  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_FULL     = 2'd1;
  localparam logic [1:0] ST_NOTFOUND = 2'd2;
  localparam logic [1:0] ST_EMPTY    = 2'd3;

  // cell commands
  localparam logic [1:0] CELL_HOLD = 2'd0;
  localparam logic [1:0] CELL_INS  = 2'd1;
  localparam logic [1:0] CELL_DEL  = 2'd2;
  localparam logic [1:0] CELL_ROT  = 2'd3;

  typedef struct packed {
    logic [1:0]              operation;
    logic signed [VAL_W-1:0] value;
  } in_item_t;

  typedef struct packed {
    logic [1:0]              status;
    logic signed [VAL_W-1:0] entry_value;
    logic                    is_last;
  } out_item_t;

  // command broadcast to every cell of the row
  typedef struct packed {
    logic [1:0]              cmd;
    logic signed [VAL_W-1:0] key;
  } cell_ctrl_t;

  // per-cell position flags
  typedef struct packed {
    logic occ;      // cell holds a live entry
    logic tail;     // last live entry
    logic left_lt;  // left neighbor is smaller than the key (set for the head)
  } cell_pos_t;

endpackage : slid_pkg
`default_nettype wire

@@ rtl/slid_cell.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// slid_cell
// One slot of the sorted row: holds one value, compares it against the key and
// takes its own, the key, a neighbor's or the head cell's value each cycle.
// ----------------------------------------------------------------------------
module slid_cell (
  input  wire logic                              clk,
  input  wire slid_pkg::cell_ctrl_t              ctrl,
  input  wire slid_pkg::cell_pos_t               pos,
  input  wire logic signed [slid_pkg::VAL_W-1:0] left_value,
  input  wire logic signed [slid_pkg::VAL_W-1:0] right_value,
  input  wire logic signed [slid_pkg::VAL_W-1:0] wrap_value,
  output logic signed [slid_pkg::VAL_W-1:0]      value,
  output logic                                   lt,
  output logic                                   eq
);
  import slid_pkg::*;

  logic signed [VAL_W-1:0] value_r;
  logic signed [VAL_W-1:0] value_nxt;

  assign value = value_r;
  assign lt    = pos.occ && (value_r < ctrl.key);
  assign eq    = pos.occ && (value_r == ctrl.key);

  always_comb begin
    value_nxt = value_r;
    unique case (ctrl.cmd)
      CELL_HOLD: value_nxt = value_r;
      // smaller entries stay; the first slot not smaller takes the key, the rest move right
      CELL_INS: begin
        if (lt) begin
          value_nxt = value_r;
        end else if (pos.left_lt) begin
          value_nxt = ctrl.key;
        end else begin
          value_nxt = left_value;
        end
      end
      // smaller entries stay; from the first match on, advance left by one
      CELL_DEL: begin
        if (lt) begin
          value_nxt = value_r;
        end else begin
          value_nxt = right_value;
        end
      end
      // rotate the live entries toward the head
      CELL_ROT: begin
        if (pos.tail) begin
          value_nxt = wrap_value;
        end else begin
          value_nxt = right_value;
        end
      end
      default: value_nxt = value_r;
    endcase
  end

  always_ff @(posedge clk) begin
    value_r <= value_nxt;
  end

endmodule : slid_cell
`default_nettype wire

@@ rtl/sorted_list_insert_delete_unit.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// sorted_list_insert_delete_unit
// Bounded ascending list of signed 32-bit values held in a row of cells.
// ----------------------------------------------------------------------------
// An item is taken when start is high and busy is low. Insert and delete
// first latch the command; then every cell compares its entry with the value
// in parallel and, on success, the entries from the insert or delete point
// on shift by one place. Each gives one result beat on the cycle after that.
// Show also latches the command first, then streams one beat per cycle as
// the live entries rotate through the head cell (a single ST_EMPTY beat when
// empty); the row is back in order once the last beat is out. An unused
// operation code gives no beat. Result beats are strobed by out_valid for
// one cycle each and cannot be held off.
// ----------------------------------------------------------------------------
module sorted_list_insert_delete_unit #(
  parameter int DEPTH = slid_pkg::DEPTH_DEF
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                start,
  output logic                     busy,
  input  wire slid_pkg::in_item_t  in_item,
  output logic                     out_valid,
  output slid_pkg::out_item_t      out_item
);
  import slid_pkg::*;

  localparam int CNT_W = $clog2(DEPTH + 1);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_EXEC = 2'd1;
  localparam logic [1:0] S_SHOW = 2'd2;

  logic [1:0]              state_r, state_nxt;
  logic [1:0]              op_r, op_nxt;
  logic signed [VAL_W-1:0] key_r, key_nxt;
  logic [CNT_W-1:0]        cnt_r, cnt_nxt;
  logic [CNT_W-1:0]        idx_r, idx_nxt;
  logic                    out_valid_r, out_valid_nxt;
  out_item_t               out_item_r, out_item_nxt;

  cell_ctrl_t              ctrl;
  cell_pos_t               pos   [DEPTH];
  logic signed [VAL_W-1:0] cval  [DEPTH];
  logic [DEPTH-1:0]        lt_v;
  logic [DEPTH-1:0]        eq_v;
  logic                    found;
  logic                    accept;
  logic [CNT_W-1:0]        idx_inc;

  assign busy      = (state_r != S_IDLE);
  assign accept    = start && !busy;
  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;
  assign found     = |eq_v;
  assign idx_inc   = idx_r + CNT_W'(1);

  // cell row
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic signed [VAL_W-1:0] left_v;
    logic signed [VAL_W-1:0] right_v;

    assign pos[i].occ     = (CNT_W'(i) < cnt_r);
    assign pos[i].tail    = (cnt_r == CNT_W'(i + 1));
    if (i == 0) begin : g_head
      assign pos[i].left_lt = 1'b1;
      assign left_v         = ctrl.key;
    end else begin : g_body
      assign pos[i].left_lt = lt_v[i-1];
      assign left_v         = cval[i-1];
    end
    if (i == DEPTH - 1) begin : g_end
      assign right_v = cval[i];
    end else begin : g_mid
      assign right_v = cval[i+1];
    end

    slid_cell u_cell (
      .clk         (clk),
      .ctrl        (ctrl),
      .pos         (pos[i]),
      .left_value  (left_v),
      .right_value (right_v),
      .wrap_value  (cval[0]),
      .value       (cval[i]),
      .lt          (lt_v[i]),
      .eq          (eq_v[i])
    );
  end

  always_comb begin
    state_nxt     = state_r;
    op_nxt        = op_r;
    key_nxt       = key_r;
    cnt_nxt       = cnt_r;
    idx_nxt       = idx_r;
    out_valid_nxt = 1'b0;
    out_item_nxt  = out_item_r;
    ctrl.cmd      = CELL_HOLD;
    ctrl.key      = key_r;

    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          op_nxt    = in_item.operation;
          key_nxt   = in_item.value;
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        state_nxt                = S_IDLE;
        out_item_nxt.entry_value = '0;
        out_item_nxt.is_last     = 1'b1;
        unique case (op_r)
          OP_INSERT: begin
            out_valid_nxt = 1'b1;
            if (cnt_r == CNT_W'(DEPTH)) begin
              out_item_nxt.status = ST_FULL;
            end else begin
              ctrl.cmd            = CELL_INS;
              cnt_nxt             = cnt_r + CNT_W'(1);
              out_item_nxt.status = ST_OK;
            end
          end
          OP_DELETE: begin
            out_valid_nxt = 1'b1;
            if (cnt_r == '0) begin
              out_item_nxt.status = ST_EMPTY;
            end else if (!found) begin
              out_item_nxt.status = ST_NOTFOUND;
            end else begin
              ctrl.cmd            = CELL_DEL;
              cnt_nxt             = cnt_r - CNT_W'(1);
              out_item_nxt.status = ST_OK;
            end
          end
          OP_SHOW: begin
            out_valid_nxt = 1'b1;
            if (cnt_r == '0) begin
              out_item_nxt.status = ST_EMPTY;
            end else begin
              // emit the head and rotate
              ctrl.cmd                 = CELL_ROT;
              out_item_nxt.status      = ST_OK;
              out_item_nxt.entry_value = cval[0];
              out_item_nxt.is_last     = (cnt_r == CNT_W'(1));
              idx_nxt                  = CNT_W'(1);
              if (cnt_r != CNT_W'(1)) begin
                state_nxt = S_SHOW;
              end
            end
          end
          OP_NONE: begin
            out_valid_nxt = 1'b0;
          end
          default: out_valid_nxt = 1'b0;
        endcase
      end
      S_SHOW: begin
        ctrl.cmd                 = CELL_ROT;
        out_valid_nxt            = 1'b1;
        out_item_nxt.status      = ST_OK;
        out_item_nxt.entry_value = cval[0];
        out_item_nxt.is_last     = (idx_inc == cnt_r);
        idx_nxt                  = idx_inc;
        if (idx_inc == cnt_r) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      idx_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      idx_r       <= idx_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r       <= op_nxt;
    key_r      <= key_nxt;
    out_item_r <= out_item_nxt;
  end

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNT_W'(DEPTH))
    else $error("entry count above depth");

  a_beat_from_work: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(busy))
    else $error("result beat without work in flight");

  a_accept_exec: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> (state_r == S_EXEC))
    else $error("accepted beat not executed");

  a_show_live: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SHOW) |-> ((cnt_r != '0) && (idx_r < cnt_r)))
    else $error("show stream past live entries");

endmodule : sorted_list_insert_delete_unit
`default_nettype wire
